/* design/pctbl_pkg.sv */
// Shared types and constants for the per-client token bucket limiter.
// Used by the top level and by its checker; has no dependencies.
package pctbl_pkg;

  localparam int ADDR_W     = 32;
  localparam int TIME_W     = 48;
  localparam int TOK_W      = 48;
  localparam int FRAC_W     = 32;
  localparam int RATE_W     = 40;
  localparam int BURST_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 40;
  localparam int META_W     = 1 + ADDR_W + TIME_W;

  // Cycles from an accepted request to its result, with no stall at the output.
  localparam int RESULT_LATENCY = 6;

  localparam logic [RATE_W-1:0]  RATE_RESET  = 40'd429497;
  localparam logic [BURST_W-1:0] BURST_RESET = 16'd2000;
  localparam logic [TOK_W-1:0]   ONE_TOKEN   = 48'h0001_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REFILL_RATE = 1'b0,
    CFG_BURST_LIMIT = 1'b1
  } cfg_reg_t;

  // One bucket's ownership record as kept in memory.
  typedef struct packed {
    logic              used;
    logic [ADDR_W-1:0] key;
    logic [TIME_W-1:0] last_time;
  } meta_t;

endpackage

/* design/pctbl_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read during a write to the same address returns the old data. No dependencies.
module pctbl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/per_client_token_bucket_limiter_top.sv */
// Per-client token bucket rate limiter, top level.
// Depends on pctbl_pkg and on pctbl_ram for the bucket tables.
//
// Usage: requests enter on the in_ channel (valid/ready) with a client
// address, an IPv4 flag and a timestamp. Each request produces exactly one
// result on the out_ channel: allowed, plus whole tokens left in the bucket.
// refill_rate (index 0) and burst_limit (index 1) are written through the
// cfg_ port while no request is in flight.
//
// One request is accepted per cycle while in_ready is high: the bucket number
// (key modulo bucket count) takes two stages, the ownership table is
// read-modified-written in one stage, the refill product takes two stages
// and the token table is updated in the last one.
// Back-to-back requests to one bucket are covered by forwarding registers.
//
// Results land in an 8-entry queue. When the receiver stalls, the pipeline
// keeps running and in_ready drops once queued plus in-flight results fill
// the queue. After reset the block sweeps the ownership table, one bucket
// per cycle, with in_ready low; configuration writes are taken during that
// sweep.
module per_client_token_bucket_limiter_top
  import pctbl_pkg::*;
#(
  parameter int unsigned BUCKET_COUNT = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ADDR_W-1:0]     in_client_addr,
  input  logic                  in_addr_is_ipv4,
  input  logic [TIME_W-1:0]     in_now_ticks,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_allowed,
  output logic [BURST_W-1:0]    out_tokens_left,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W  = $clog2(BUCKET_COUNT);
  localparam int FOLD_W = IDX_W + 10;
  localparam int M_W    = FOLD_W + 1;
  localparam int SHIFT  = FOLD_W + IDX_W;
  localparam int Q_W    = FOLD_W - IDX_W + 1;
  localparam int QC_W   = Q_W + IDX_W + 1;

  // Reciprocal of the bucket count, exact for every folded key value.
  localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(BUCKET_COUNT) - 64'd1) / 64'(BUCKET_COUNT);
  localparam logic [M_W-1:0] RECIP = RECIP_FULL[M_W-1:0];

  // Weights of the key bytes modulo the bucket count.
  localparam logic [63:0] W1_FULL = 64'd256 % 64'(BUCKET_COUNT);
  localparam logic [63:0] W2_FULL = 64'd65536 % 64'(BUCKET_COUNT);
  localparam logic [63:0] W3_FULL = 64'd16777216 % 64'(BUCKET_COUNT);
  localparam logic [IDX_W-1:0] W1 = W1_FULL[IDX_W-1:0];
  localparam logic [IDX_W-1:0] W2 = W2_FULL[IDX_W-1:0];
  localparam logic [IDX_W-1:0] W3 = W3_FULL[IDX_W-1:0];

  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = 3;
  localparam int CNT_W      = 4;

  // Configuration.
  logic [RATE_W-1:0]  rate_r;
  logic [BURST_W-1:0] burst_r;

  // Reset sweep of the ownership table.
  logic             clr_r;
  logic [IDX_W-1:0] clr_idx_r;

  // Stage f1: folded key.
  logic              f1_v_r;
  logic [ADDR_W-1:0] f1_key_r;
  logic [TIME_W-1:0] f1_now_r;
  logic [FOLD_W-1:0] f1_fold_r;
  logic [ADDR_W-1:0] in_key;
  logic [FOLD_W-1:0] f1_fold_nxt;

  // Stage f2: quotient, then remainder and table read.
  logic              f2_v_r;
  logic [ADDR_W-1:0] f2_key_r;
  logic [TIME_W-1:0] f2_now_r;
  logic [FOLD_W-1:0] f2_fold_r;
  logic [Q_W-1:0]    f2_q_r;
  logic [FOLD_W+M_W-1:0] f1_prod;
  logic [QC_W-1:0]   f2_qc;
  logic [FOLD_W-1:0] f2_rem;
  logic [FOLD_W-1:0] f2_rem_fix;
  logic [IDX_W-1:0]  f2_idx;

  // Stage a: ownership check and elapsed time.
  logic              a_v_r;
  logic [ADDR_W-1:0] a_key_r;
  logic [TIME_W-1:0] a_now_r;
  logic [IDX_W-1:0]  a_idx_r;
  meta_t             meta_rdata;
  meta_t             meta_cur;
  meta_t             meta_wdata;
  logic              meta_we;
  logic [IDX_W-1:0]  meta_waddr;
  logic              a_fwd;
  logic              a_hit;
  logic [TIME_W-1:0] a_elapsed;
  logic [63:0]       mul_ll;
  logic [39:0]       mul_lh;
  logic [47:0]       mul_hl;

  // Last ownership write, for the next request to the same bucket.
  logic              w_v_r;
  logic [IDX_W-1:0]  w_idx_r;
  logic [ADDR_W-1:0] w_key_r;
  logic [TIME_W-1:0] w_now_r;

  // Stage b: partial products of elapsed * rate.
  logic              b_v_r;
  logic [IDX_W-1:0]  b_idx_r;
  logic              b_claim_r;
  logic [63:0]       b_ll_r;
  logic [39:0]       b_lh_r;
  logic [47:0]       b_hl_r;
  logic              b_sat_r;
  logic [48:0]       b_mid;
  logic [64:0]       b_total;
  logic              b_sat;

  // Stage c: token update.
  logic              c_v_r;
  logic [IDX_W-1:0]  c_idx_r;
  logic              c_claim_r;
  logic [TOK_W-1:0]  c_prod_r;
  logic              c_sat_r;
  logic [TOK_W-1:0]  tok_rdata;
  logic [TOK_W-1:0]  c_cap;
  logic [TOK_W-1:0]  c_old;
  logic [TOK_W-1:0]  c_base;
  logic [TOK_W:0]    c_sum;
  logic [TOK_W-1:0]  c_refilled;
  logic              c_allowed;
  logic [TOK_W-1:0]  c_after;

  // Last token write.
  logic              d_v_r;
  logic [IDX_W-1:0]  d_idx_r;
  logic [TOK_W-1:0]  d_tok_r;

  // Result queue.
  logic               fifo_allowed_r [FIFO_DEPTH];
  logic [BURST_W-1:0] fifo_left_r    [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic [CNT_W-1:0]   occupancy;
  logic               in_fire;
  logic               out_fire;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= RATE_RESET;
      burst_r <= BURST_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_REFILL_RATE: rate_r  <= cfg_wdata[RATE_W-1:0];
        CFG_BURST_LIMIT: burst_r <= cfg_wdata[BURST_W-1:0];
        default: ;
      endcase
    end
  end

  // ----------------------------------------------------------- reset sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == IDX_W'(BUCKET_COUNT - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------ admission control
  assign occupancy = CNT_W'(f1_v_r) + CNT_W'(f2_v_r) + CNT_W'(a_v_r) + CNT_W'(b_v_r)
                   + CNT_W'(c_v_r) + cnt_r;
  assign in_ready  = !clr_r && (occupancy < CNT_W'(FIFO_DEPTH));
  assign in_fire   = in_valid && in_ready;

  // ------------------------------------------------------------- stage f1
  // key mod BUCKET_COUNT is folded bytewise into a short value first.
  assign in_key      = in_addr_is_ipv4 ? in_client_addr : '0;
  assign f1_fold_nxt = FOLD_W'(in_key[7:0])
                     + FOLD_W'(in_key[15:8])  * FOLD_W'(W1)
                     + FOLD_W'(in_key[23:16]) * FOLD_W'(W2)
                     + FOLD_W'(in_key[31:24]) * FOLD_W'(W3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else begin
      f1_v_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    f1_key_r  <= in_key;
    f1_now_r  <= in_now_ticks;
    f1_fold_r <= f1_fold_nxt;
  end

  // ------------------------------------------------------------- stage f2
  assign f1_prod = (FOLD_W + M_W)'(f1_fold_r) * (FOLD_W + M_W)'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_v_r <= 1'b0;
    end else begin
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    f2_key_r  <= f1_key_r;
    f2_now_r  <= f1_now_r;
    f2_fold_r <= f1_fold_r;
    f2_q_r    <= f1_prod[SHIFT +: Q_W];
  end

  assign f2_qc      = QC_W'(f2_q_r) * QC_W'(BUCKET_COUNT);
  assign f2_rem     = f2_fold_r - f2_qc[FOLD_W-1:0];
  assign f2_rem_fix = (f2_rem >= FOLD_W'(BUCKET_COUNT)) ? f2_rem - FOLD_W'(BUCKET_COUNT)
                                                         : f2_rem;
  assign f2_idx     = f2_rem_fix[IDX_W-1:0];

  // -------------------------------------------------------------- stage a
  pctbl_ram #(
    .WIDTH (META_W),
    .DEPTH (BUCKET_COUNT)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (f2_idx),
    .rdata (meta_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    a_key_r <= f2_key_r;
    a_now_r <= f2_now_r;
    a_idx_r <= f2_idx;
  end

  // The previous request wrote this table in the cycle our read was issued.
  assign a_fwd = w_v_r && (w_idx_r == a_idx_r);

  always_comb begin
    meta_cur = meta_rdata;
    if (a_fwd) begin
      meta_cur.used      = 1'b1;
      meta_cur.key       = w_key_r;
      meta_cur.last_time = w_now_r;
    end
  end

  assign a_hit     = meta_cur.used && (meta_cur.key == a_key_r);
  assign a_elapsed = (a_hit && (a_now_r >= meta_cur.last_time)) ?
                     a_now_r - meta_cur.last_time : '0;

  always_comb begin
    meta_we    = a_v_r || clr_r;
    meta_waddr = a_idx_r;
    meta_wdata.used      = 1'b1;
    meta_wdata.key       = a_key_r;
    meta_wdata.last_time = a_now_r;
    if (clr_r) begin
      meta_waddr = clr_idx_r;
      meta_wdata = '0;
    end
  end

  assign mul_ll = 64'(a_elapsed[31:0]) * 64'(rate_r[31:0]);
  assign mul_lh = 40'(a_elapsed[31:0]) * 40'(rate_r[39:32]);
  assign mul_hl = 48'(a_elapsed[47:32]) * 48'(rate_r[31:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      w_v_r <= a_v_r;
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    w_idx_r   <= a_idx_r;
    w_key_r   <= a_key_r;
    w_now_r   <= a_now_r;
    b_idx_r   <= a_idx_r;
    b_claim_r <= !a_hit;
    b_ll_r    <= mul_ll;
    b_lh_r    <= mul_lh;
    b_hl_r    <= mul_hl;
    b_sat_r   <= (|a_elapsed[47:32]) && (|rate_r[39:32]);
  end

  // -------------------------------------------------------------- stage b
  // Any product at or above 2^48 exceeds every possible headroom.
  assign b_mid   = 49'(b_lh_r) + 49'(b_hl_r);
  assign b_total = 65'(b_ll_r) + 65'({b_mid[15:0], {FRAC_W{1'b0}}});
  assign b_sat   = b_sat_r || (|b_mid[48:16]) || (|b_total[64:48]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    c_idx_r   <= b_idx_r;
    c_claim_r <= b_claim_r;
    c_prod_r  <= b_total[TOK_W-1:0];
    c_sat_r   <= b_sat;
  end

  // -------------------------------------------------------------- stage c
  pctbl_ram #(
    .WIDTH (TOK_W),
    .DEPTH (BUCKET_COUNT)
  ) u_tok_ram (
    .clk   (clk),
    .we    (c_v_r),
    .waddr (c_idx_r),
    .wdata (c_after),
    .raddr (b_idx_r),
    .rdata (tok_rdata)
  );

  assign c_cap  = {burst_r, {FRAC_W{1'b0}}};
  assign c_old  = (d_v_r && (d_idx_r == c_idx_r)) ? d_tok_r : tok_rdata;
  assign c_base = c_claim_r ? c_cap : c_old;
  assign c_sum  = {1'b0, c_base} + {1'b0, c_prod_r};

  // Held tokens above a lowered burst are clamped before the refill.
  assign c_refilled = ((c_base >= c_cap) || c_sat_r || (c_sum >= {1'b0, c_cap})) ?
                      c_cap : c_sum[TOK_W-1:0];
  assign c_allowed  = c_refilled >= ONE_TOKEN;
  assign c_after    = c_allowed ? c_refilled - ONE_TOKEN : c_refilled;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else begin
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    d_idx_r <= c_idx_r;
    d_tok_r <= c_after;
  end

  // --------------------------------------------------------- result queue
  assign out_fire = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (c_v_r && !out_fire) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!c_v_r && out_fire) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (c_v_r) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_v_r) begin
      fifo_allowed_r[wr_ptr_r] <= c_allowed;
      fifo_left_r[wr_ptr_r]    <= c_after[TOK_W-1:FRAC_W];
    end
  end

  assign out_valid       = cnt_r != '0;
  assign out_allowed     = fifo_allowed_r[rd_ptr_r];
  assign out_tokens_left = fifo_left_r[rd_ptr_r];

endmodule

/* design/pctbl_checker.sv */
// Port-level checker for the per-client token bucket limiter, bound to the top.
// Depends on pctbl_pkg for field widths and the result latency.
module pctbl_checker
  import pctbl_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_allowed,
  input logic [BURST_W-1:0]    out_tokens_left
);

  // After reset the queue is empty and the table sweep holds off requests.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("outputs not quiet after reset");

  // A refused request always leaves less than one whole token.
  a_refused_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_allowed |-> out_tokens_left == '0)
    else $error("refused request reports whole tokens left");

  // A result held by the receiver does not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_allowed)
                                && $stable(out_tokens_left))
    else $error("stalled result changed");

  // A result reaching an empty output comes from a request taken a fixed time before.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, RESULT_LATENCY))
    else $error("result without a matching request");

endmodule

bind per_client_token_bucket_limiter_top pctbl_checker u_pctbl_checker (.*);

/* tb/sv/tb_per_client_token_bucket_limiter_top.sv */
// Self-checking testbench for per_client_token_bucket_limiter_top.
// Keeps its own bucket table to predict every verdict; depends on pctbl_pkg and the RTL.
// Directed cases come first, then random phases under several rate and burst settings.
module tb_per_client_token_bucket_limiter_top
  import pctbl_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BUCKET_COUNT = 512;
  localparam int unsigned POOL_SIZE    = 16;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  typedef struct {
    logic               allowed;
    logic [BURST_W-1:0] tokens_left;
    int unsigned        seq;
  } verdict_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [ADDR_W-1:0]     in_client_addr;
  logic                  in_addr_is_ipv4;
  logic [TIME_W-1:0]     in_now_ticks;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_allowed;
  logic [BURST_W-1:0]    out_tokens_left;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Predicted bucket table and register copies.
  logic                bkt_used   [BUCKET_COUNT];
  logic [ADDR_W-1:0]   bkt_key    [BUCKET_COUNT];
  logic [TOK_W-1:0]    bkt_tokens [BUCKET_COUNT];
  logic [TIME_W-1:0]   bkt_stamp  [BUCKET_COUNT];
  logic [RATE_W-1:0]   rate_q32;
  logic [BURST_W-1:0]  burst_whole;

  verdict_t            verdict_q[$];
  int unsigned         error_count;
  int unsigned         request_seq;
  int unsigned         cycle_count;
  bit                  tx_idle_on;
  bit                  rx_idle_on;
  bit                  rx_hold_req;
  logic [TIME_W-1:0]   now_t;
  logic [ADDR_W-1:0]   pool_addr [POOL_SIZE];
  logic                pool_ipv4 [POOL_SIZE];

  per_client_token_bucket_limiter_top #(
    .BUCKET_COUNT(BUCKET_COUNT)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_client_addr (in_client_addr),
    .in_addr_is_ipv4(in_addr_is_ipv4),
    .in_now_ticks   (in_now_ticks),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_allowed    (out_allowed),
    .out_tokens_left(out_tokens_left),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    if (error_count < 100) $display("MISMATCH: %s", what);
    error_count++;
  endtask

  function automatic void reset_bucket_model();
    foreach (bkt_used[i]) begin
      bkt_used[i]   = 1'b0;
      bkt_key[i]    = '0;
      bkt_tokens[i] = '0;
      bkt_stamp[i]  = '0;
    end
    rate_q32    = RATE_RESET;
    burst_whole = BURST_RESET;
  endfunction

  // Claims the bucket if needed, refills it with saturation and spends one token when it holds one.
  function automatic verdict_t predict_bucket_verdict(input logic [ADDR_W-1:0] addr,
                                                      input logic ipv4,
                                                      input logic [TIME_W-1:0] stamp);
    logic [ADDR_W-1:0] key;
    int unsigned       idx;
    logic [63:0]       cap;
    logic [63:0]       tok;
    logic [63:0]       room;
    logic [63:0]       elapsed;
    logic [63:0]       rate;
    verdict_t          v;
    key = ipv4 ? addr : '0;
    idx = key % BUCKET_COUNT;
    cap = 64'(burst_whole) << FRAC_W;
    if (!bkt_used[idx] || bkt_key[idx] != key) begin
      bkt_used[idx]   = 1'b1;
      bkt_key[idx]    = key;
      bkt_tokens[idx] = cap[TOK_W-1:0];
      bkt_stamp[idx]  = stamp;
    end
    // A timestamp that goes backwards adds nothing but still becomes the stored time.
    elapsed = (stamp >= bkt_stamp[idx]) ? 64'(stamp - bkt_stamp[idx]) : 64'd0;
    tok     = 64'(bkt_tokens[idx]);
    rate    = 64'(rate_q32);
    if (tok >= cap) begin
      tok = cap;
    end else if (rate != 0 && elapsed != 0) begin
      room = cap - tok;
      if (elapsed > room / rate) tok = cap;
      else tok = tok + elapsed * rate;
    end
    bkt_stamp[idx] = stamp;
    v.allowed = (tok >= 64'(ONE_TOKEN));
    if (v.allowed) tok = tok - 64'(ONE_TOKEN);
    bkt_tokens[idx] = tok[TOK_W-1:0];
    v.tokens_left   = tok[FRAC_W +: BURST_W];
    v.seq           = 0;
    return v;
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_REFILL_RATE: rate_q32 = value[RATE_W-1:0];
      CFG_BURST_LIMIT: burst_whole = value[BURST_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_request(input logic [ADDR_W-1:0] addr, input logic ipv4,
                              input logic [TIME_W-1:0] stamp);
    verdict_t v;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_client_addr  <= addr;
    in_addr_is_ipv4 <= ipv4;
    in_now_ticks    <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    v     = predict_bucket_verdict(addr, ipv4, stamp);
    v.seq = request_seq++;
    verdict_q.push_back(v);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (verdict_q.size() != 0);
  endtask

  always @(posedge clk) begin : result_checker
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: allowed=%0b left=%0d",
                                  out_allowed, out_tokens_left));
      end else begin
        want = verdict_q.pop_front();
        if (out_allowed !== want.allowed)
          report_mismatch($sformatf("request %0d allowed: got %0b want %0b",
                                    want.seq, out_allowed, want.allowed));
        if (out_tokens_left !== want.tokens_left)
          report_mismatch($sformatf("request %0d tokens_left: got %0d want %0d",
                                    want.seq, out_tokens_left, want.tokens_left));
      end
    end
  end

  initial begin : result_receiver
    int unsigned hold_cnt;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
        rx_hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Random traffic from a small client pool, with deliberate collisions on the
  // bucket index, non-IPv4 clients, and occasional time jumps in both directions.
  task automatic run_random_phase(input int unsigned count, input logic [CFG_DATA_W-1:0] rate,
                                  input logic [BURST_W-1:0] burst,
                                  input int unsigned step_max);
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] addr;
    logic              ipv4;
    logic [TIME_W-1:0] stamp;
    int unsigned       k;
    int unsigned       r;
    drain_results();
    write_reg(CFG_REFILL_RATE, rate);
    write_reg(CFG_BURST_LIMIT, CFG_DATA_W'(burst));
    base = $urandom;
    for (int i = 0; i < POOL_SIZE; i++) begin
      addr = $urandom;
      case (i % 4)
        0: pool_ipv4[i] = 1'b1;
        1: begin
          addr[8:0]    = base[8:0];
          pool_ipv4[i] = 1'b1;
        end
        2: pool_ipv4[i] = 1'b0;
        default: begin
          addr[8:0]    = 9'($urandom_range(0, 3));
          pool_ipv4[i] = 1'b1;
        end
      endcase
      pool_addr[i] = addr;
    end
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) begin
        addr = $urandom;
        ipv4 = 1'($urandom_range(0, 1));
      end else begin
        k    = $urandom_range(0, POOL_SIZE - 1);
        addr = pool_addr[k];
        ipv4 = pool_ipv4[k];
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        stamp = now_t - TIME_W'($urandom_range(1, 500));
      end else if (r < 5) begin
        now_t = TIME_W'({$urandom, $urandom});
        stamp = now_t;
      end else begin
        now_t = now_t + TIME_W'($urandom_range(0, step_max));
        stamp = now_t;
      end
      send_request(addr, ipv4, stamp);
    end
    drain_results();
  endtask

  task automatic test_claim_and_share();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_request(32'h0A00_0001, 1'b1, 48'd1000);
    send_request(32'h0A00_0001, 1'b1, 48'd1000);
    send_request(32'h0A00_0001, 1'b1, 48'd1001);
    // Every non-IPv4 client lands on key zero, as does address zero itself.
    send_request(32'hFFFF_FFFF, 1'b0, 48'd2000);
    send_request(32'h0000_0000, 1'b1, 48'd2000);
    send_request(32'h1234_5600, 1'b0, 48'd2001);
    // Same bucket index, different key: the bucket is taken over.
    send_request(32'h0000_0200, 1'b1, 48'd2002);
    send_request(32'h0000_0000, 1'b0, 48'd2003);
  endtask

  task automatic test_time_extremes();
    send_request(32'hFFFF_FFFF, 1'b1, 48'h0);
    send_request(32'hFFFF_FFFF, 1'b1, 48'hFFFF_FFFF_FFFF);
    send_request(32'hFFFF_FFFF, 1'b1, 48'h0);
    send_request(32'hFFFF_FFFF, 1'b1, 48'h8000_0000_0000);
    send_request(32'h5555_5555, 1'b1, 48'h5555_5555_5555);
    send_request(32'hAAAA_AAAA, 1'b1, 48'hAAAA_AAAA_AAAA);
  endtask

  task automatic test_burst_and_rate_extremes();
    // Lowering the burst below what a bucket holds clamps it on its next visit.
    drain_results();
    write_reg(CFG_BURST_LIMIT, CFG_DATA_W'(1));
    write_reg(CFG_REFILL_RATE, '0);
    send_request(32'h0A00_0001, 1'b1, 48'd5000);
    send_request(32'h0A00_0001, 1'b1, 48'd900000);
    drain_results();
    write_reg(CFG_BURST_LIMIT, '0);
    send_request(32'h0A00_0002, 1'b1, 48'd900001);
    send_request(32'h0A00_0001, 1'b1, 48'd900002);
    drain_results();
    write_reg(CFG_BURST_LIMIT, CFG_DATA_W'(16'hFFFF));
    write_reg(CFG_REFILL_RATE, {CFG_DATA_W{1'b1}});
    send_request(32'h0A00_0003, 1'b1, 48'd900003);
    send_request(32'h0A00_0003, 1'b1, 48'd900004);
    send_request(32'h0A00_0003, 1'b1, 48'd900004);
  endtask

  task automatic test_random_tight_buckets();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    now_t      = 48'd1_000_000;
    run_random_phase(450, CFG_DATA_W'(ONE_TOKEN / $urandom_range(20, 200)),
                     BURST_W'($urandom_range(2, 8)), 8);
  endtask

  task automatic test_random_wide_buckets();
    run_random_phase(250, {CFG_DATA_W{1'b1}}, 16'hFFFF, 4);
    run_random_phase(150, CFG_DATA_W'(RATE_RESET), BURST_RESET, 2000);
  endtask

  task automatic test_random_no_refill();
    run_random_phase(200, '0, BURST_W'($urandom_range(1, 20)), 50);
  endtask

  task automatic test_random_zero_burst();
    run_random_phase(100, CFG_DATA_W'(ONE_TOKEN / 10), '0, 20);
  endtask

  task automatic test_backpressure_hold();
    // The receiver stops for a long stretch while requests keep coming.
    tx_idle_on  = 1'b0;
    rx_hold_req = 1'b1;
    run_random_phase(80, CFG_DATA_W'(ONE_TOKEN / 20), 16'd8, 4);
  endtask

  task automatic test_random_no_idling();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_random_phase(400, CFG_DATA_W'(ONE_TOKEN / $urandom_range(10, 100)),
                     BURST_W'($urandom_range(3, 8)), 6);
  endtask

  initial begin
    in_valid        <= 1'b0;
    in_client_addr  <= '0;
    in_addr_is_ipv4 <= 1'b0;
    in_now_ticks    <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_REFILL_RATE;
    cfg_wdata       <= '0;
    rst_n           <= 1'b0;
    error_count = 0;
    request_seq = 0;
    tx_idle_on  = 1'b0;
    rx_idle_on  = 1'b0;
    rx_hold_req = 1'b0;
    now_t       = '0;
    reset_bucket_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_claim_and_share();
    test_time_extremes();
    test_burst_and_rate_extremes();
    test_random_tight_buckets();
    test_random_wide_buckets();
    test_random_no_refill();
    test_random_zero_burst();
    test_backpressure_hold();
    test_random_no_idling();

    drain_results();
    repeat (RESULT_LATENCY + 4) @(posedge clk);
    if (verdict_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", verdict_q.size()));
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
